// File: hw/rtl/atcar_pkg.sv
// Shared types and default sizes for the associative tag cache.
`default_nettype none
package atcar_pkg;

   localparam int NUM_SLOTS_DEF   = 64;
   localparam int AGE_BITS_DEF    = 16;
   localparam int KEY_BITS_DEF    = 48;
   localparam int SLOT_INDEX_BITS = 6;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic valid;
      logic have_empty;
      logic have_old;
      logic hit;
   } scan_ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/atcar_cell.sv
// One cache slot: key, valid, age, and one stage of the scan wavefront.
`default_nettype none
module atcar_cell
   import atcar_pkg::*;
#(
   parameter int IDX_BITS = 6,
   parameter int AGE_BITS = AGE_BITS_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [IDX_BITS-1:0] slot_id,
   input  wire logic [KEY_BITS-1:0] lookup_key,
   input  wire logic                clear_all,
   input  wire logic                install_en,
   input  wire logic [IDX_BITS-1:0] install_idx,
   input  wire scan_ctl_type        tok_ctl_in,
   input  wire logic [IDX_BITS-1:0] empty_idx_in,
   input  wire logic [IDX_BITS-1:0] old_idx_in,
   input  wire logic [AGE_BITS-1:0] old_age_in,
   input  wire logic [IDX_BITS-1:0] hit_idx_in,
   output scan_ctl_type             tok_ctl_out,
   output logic      [IDX_BITS-1:0] empty_idx_out,
   output logic      [IDX_BITS-1:0] old_idx_out,
   output logic      [AGE_BITS-1:0] old_age_out,
   output logic      [IDX_BITS-1:0] hit_idx_out
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                valid_ff, valid_in;
   logic [AGE_BITS-1:0] age_ff, age_in;
   logic [AGE_BITS-1:0] age_inc;
   logic                match;
   logic                install_sel;

   scan_ctl_type        tok_ctl_ff, tok_ctl_in_nx;
   logic [IDX_BITS-1:0] empty_idx_ff, empty_idx_in_nx;
   logic [IDX_BITS-1:0] old_idx_ff, old_idx_in_nx;
   logic [AGE_BITS-1:0] old_age_ff, old_age_in_nx;
   logic [IDX_BITS-1:0] hit_idx_ff, hit_idx_in_nx;

   always_comb begin
      age_inc     = (age_ff == '1) ? age_ff : age_ff + 1'b1;
      match       = valid_ff && (key_ff == lookup_key);
      install_sel = install_en && (install_idx == slot_id);
   end

   // scan stage
   always_comb begin
      tok_ctl_in_nx   = tok_ctl_in;
      empty_idx_in_nx = empty_idx_in;
      old_idx_in_nx   = old_idx_in;
      old_age_in_nx   = old_age_in;
      hit_idx_in_nx   = hit_idx_in;
      if (tok_ctl_in.valid) begin
         if (!valid_ff) begin
            if (!tok_ctl_in.have_empty) begin
               tok_ctl_in_nx.have_empty = 1'b1;
               empty_idx_in_nx          = slot_id;
            end
         end else begin
            if (!tok_ctl_in.have_old || (age_inc > old_age_in)) begin
               tok_ctl_in_nx.have_old = 1'b1;
               old_idx_in_nx          = slot_id;
               old_age_in_nx          = age_inc;
            end
            if (match && !tok_ctl_in.hit) begin
               tok_ctl_in_nx.hit = 1'b1;
               hit_idx_in_nx     = slot_id;
            end
         end
      end
   end

   // slot state
   always_comb begin
      key_in   = install_sel ? lookup_key : key_ff;
      priority if (clear_all) begin
         valid_in = 1'b0;
      end else if (install_sel) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff;
      end
      priority if (install_sel) begin
         age_in = '0;
      end else if (tok_ctl_in.valid && valid_ff) begin
         age_in = match ? '0 : age_inc;
      end else begin
         age_in = age_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         age_ff     <= '0;
         tok_ctl_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         age_ff     <= age_in;
         tok_ctl_ff <= tok_ctl_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      empty_idx_ff <= empty_idx_in_nx;
      old_idx_ff   <= old_idx_in_nx;
      old_age_ff   <= old_age_in_nx;
      hit_idx_ff   <= hit_idx_in_nx;
   end

   assign tok_ctl_out   = tok_ctl_ff;
   assign empty_idx_out = empty_idx_ff;
   assign old_idx_out   = old_idx_ff;
   assign old_age_out   = old_age_ff;
   assign hit_idx_out   = hit_idx_ff;

endmodule
`default_nettype wire

// File: hw/rtl/assoc_tag_cache_age_replace_core.sv
// Top level: fully associative tag cache with age-based replacement.
//
//  channel   ports                                   transaction
//  request   start, busy, req_*                      start && !busy at a clock edge
//  response  rsp_valid, rsp_*                        rsp_valid high for one cycle
//
//  A clear leaves busy low; the response follows the next cycle.
//  A lookup sends a scan wavefront down the slot chain one slot per cycle,
//  then the hit or install is resolved and written back.
//  Reset clears every valid bit and age at once; no sweep follows.
//  The response cannot be stalled; busy drops in the cycle the response shows.
`default_nettype none
module assoc_tag_cache_age_replace_core
   import atcar_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int AGE_BITS  = AGE_BITS_DEF,
   parameter int KEY_BITS  = KEY_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_action,
   input  wire logic [KEY_BITS-1:0]        req_key_addr,
   input  wire logic                       req_fill_ok,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic                            rsp_installed,
   output logic [SLOT_INDEX_BITS-1:0]      rsp_slot_index
);

   localparam int IDX_BITS = $clog2(NUM_SLOTS);

   state_type           state_ff, state_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                fill_ff, fill_in;
   logic                launch_ff, launch_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic                       rsp_installed_ff, rsp_installed_in;
   logic [SLOT_INDEX_BITS-1:0] rsp_slot_index_ff, rsp_slot_index_in;

   logic                accept;
   logic                clear_all;
   logic                done;
   logic                install_en;
   logic [IDX_BITS-1:0] install_idx;

   scan_ctl_type        tok_ctl   [NUM_SLOTS+1];
   logic [IDX_BITS-1:0] empty_idx [NUM_SLOTS+1];
   logic [IDX_BITS-1:0] old_idx   [NUM_SLOTS+1];
   logic [AGE_BITS-1:0] old_age   [NUM_SLOTS+1];
   logic [IDX_BITS-1:0] hit_idx   [NUM_SLOTS+1];

   always_comb begin
      tok_ctl[0]       = '0;
      tok_ctl[0].valid = launch_ff;
      empty_idx[0]     = '0;
      old_idx[0]       = '0;
      old_age[0]       = '0;
      hit_idx[0]       = '0;
   end

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      atcar_cell #(
         .IDX_BITS (IDX_BITS),
         .AGE_BITS (AGE_BITS),
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .slot_id       (IDX_BITS'(i)),
         .lookup_key    (key_ff),
         .clear_all     (clear_all),
         .install_en    (install_en),
         .install_idx   (install_idx),
         .tok_ctl_in    (tok_ctl[i]),
         .empty_idx_in  (empty_idx[i]),
         .old_idx_in    (old_idx[i]),
         .old_age_in    (old_age[i]),
         .hit_idx_in    (hit_idx[i]),
         .tok_ctl_out   (tok_ctl[i+1]),
         .empty_idx_out (empty_idx[i+1]),
         .old_idx_out   (old_idx[i+1]),
         .old_age_out   (old_age[i+1]),
         .hit_idx_out   (hit_idx[i+1])
      );
   end

   assign accept    = start && (state_ff == ST_IDLE);
   assign clear_all = accept && req_action;
   assign done      = (state_ff == ST_SCAN) && tok_ctl[NUM_SLOTS].valid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_action) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      busy        = (state_ff != ST_IDLE);
      key_in      = accept ? req_key_addr : key_ff;
      fill_in     = accept ? req_fill_ok : fill_ff;
      launch_in   = accept && !req_action;
      install_en  = done && !tok_ctl[NUM_SLOTS].hit && fill_ff;
      install_idx = tok_ctl[NUM_SLOTS].have_empty ? empty_idx[NUM_SLOTS]
                                                  : old_idx[NUM_SLOTS];
      rsp_valid_in      = clear_all || done;
      rsp_hit_in        = done && tok_ctl[NUM_SLOTS].hit;
      rsp_installed_in  = install_en;
      priority if (rsp_hit_in) begin
         rsp_slot_index_in =
            SLOT_INDEX_BITS'({{SLOT_INDEX_BITS{1'b0}}, hit_idx[NUM_SLOTS]});
      end else if (install_en) begin
         rsp_slot_index_in =
            SLOT_INDEX_BITS'({{SLOT_INDEX_BITS{1'b0}}, install_idx});
      end else begin
         rsp_slot_index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff            <= key_in;
      fill_ff           <= fill_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_installed_ff  <= rsp_installed_in;
      rsp_slot_index_ff <= rsp_slot_index_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_installed  = rsp_installed_ff;
   assign rsp_slot_index = rsp_slot_index_ff;

endmodule
`default_nettype wire

// File: hw/rtl/atcar_checker.sv
// Port-level assertions for the tag cache, bound to the top level.
`default_nettype none
module atcar_checker
   import atcar_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic                       req_action,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_hit,
   input wire logic                       rsp_installed,
   input wire logic [SLOT_INDEX_BITS-1:0] rsp_slot_index
);

   a_hit_xor_install: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_installed))
      else $error("hit and install in one transaction");

   a_idle_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit && !rsp_installed) |-> (rsp_slot_index == '0))
      else $error("nonzero slot index without hit or install");

   a_clear_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action) |=> (rsp_valid && !rsp_hit && !rsp_installed))
      else $error("clear transaction response missing or wrong");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_action) |=> (busy && !rsp_valid))
      else $error("lookup did not raise busy");

   a_resp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

endmodule

bind assoc_tag_cache_age_replace_core atcar_checker u_atcar_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_action     (req_action),
   .rsp_valid      (rsp_valid),
   .rsp_hit        (rsp_hit),
   .rsp_installed  (rsp_installed),
   .rsp_slot_index (rsp_slot_index)
);
`default_nettype wire

// File: tb/tb_assoc_tag_cache_age_replace_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the associative tag cache with age-based replacement.
module tb_assoc_tag_cache_age_replace_core;
   import atcar_pkg::*;

   localparam int   NSLOT       = NUM_SLOTS_DEF;
   localparam int   KEYW        = KEY_BITS_DEF;
   localparam int   AGEW        = AGE_BITS_DEF;
   localparam logic ACT_LOOKUP  = 1'b0;
   localparam logic ACT_CLEAR   = 1'b1;
   localparam int   CYCLE_LIMIT = 600_000;
   localparam int   RANDOM_TXNS = 860;
   localparam int   QUIET_TAIL  = 150;
   localparam int   MAX_REPORTS = 10;

   typedef logic [KEYW-1:0] key_type;

   typedef struct packed {
      logic                       hit;
      logic                       installed;
      logic [SLOT_INDEX_BITS-1:0] slot;
   } cache_resp_type;

   logic clock        = 1'b0;
   logic reset        = 1'b1;
   logic start        = 1'b0;
   logic req_action   = ACT_LOOKUP;
   key_type req_key_addr = '0;
   logic req_fill_ok  = 1'b0;
   logic busy;
   logic rsp_valid;
   logic rsp_hit;
   logic rsp_installed;
   logic [SLOT_INDEX_BITS-1:0] rsp_slot_index;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assoc_tag_cache_age_replace_core u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_key_addr   (req_key_addr),
      .req_fill_ok    (req_fill_ok),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_installed  (rsp_installed),
      .rsp_slot_index (rsp_slot_index)
   );

   // shadow copy of the cache
   key_type         tag_key   [NSLOT];
   logic            tag_valid [NSLOT];
   logic [AGEW-1:0] tag_age   [NSLOT];

   cache_resp_type pending_resps[$];
   cache_resp_type want;

   int cycle_count   = 0;
   int fail_count    = 0;
   int resp_checked  = 0;
   int n_lookups     = 0;
   int n_hits        = 0;
   int n_installs    = 0;
   int n_evictions   = 0;
   int n_clears      = 0;
   int n_dry_misses  = 0;

   initial begin
      foreach (tag_valid[i]) begin
         tag_key[i]   = '0;
         tag_valid[i] = 1'b0;
         tag_age[i]   = '0;
      end
   end

   function automatic cache_resp_type predict_cache_access(logic act, key_type key, logic fill);
      cache_resp_type r;
      bit          have_empty;
      bit          have_old;
      int          empty_slot;
      int          old_slot;
      int          tgt;
      r          = '0;
      have_empty = 1'b0;
      have_old   = 1'b0;
      empty_slot = 0;
      old_slot   = 0;
      if (act == ACT_CLEAR) begin
         foreach (tag_valid[i]) tag_valid[i] = 1'b0;
         n_clears++;
      end else begin
         n_lookups++;
         for (int i = 0; i < NSLOT; i++) begin
            if (!tag_valid[i]) begin
               if (!have_empty) begin
                  have_empty = 1'b1;
                  empty_slot = i;
               end
            end else begin
               if (tag_age[i] != '1) tag_age[i]++;
               if (!have_old || tag_age[i] > tag_age[old_slot]) begin
                  have_old = 1'b1;
                  old_slot = i;
               end
            end
         end
         for (int i = 0; i < NSLOT; i++) begin
            if (tag_valid[i] && tag_key[i] == key) begin
               tag_age[i] = '0;
               if (!r.hit) begin
                  r.hit  = 1'b1;
                  r.slot = SLOT_INDEX_BITS'(i);
               end
            end
         end
         if (r.hit) begin
            n_hits++;
         end else if (fill) begin
            tgt            = have_empty ? empty_slot : old_slot;
            tag_key[tgt]   = key;
            tag_valid[tgt] = 1'b1;
            tag_age[tgt]   = '0;
            r.installed    = 1'b1;
            r.slot         = SLOT_INDEX_BITS'(tgt);
            n_installs++;
            if (!have_empty) n_evictions++;
         end else begin
            n_dry_misses++;
         end
      end
      return r;
   endfunction

   function automatic key_type rand_key();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[KEYW-1:0];
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_resps.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         resp_checked++;
         if (pending_resps.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected response at cycle %0d: hit=%0b installed=%0b slot=%0d",
                        cycle_count, rsp_hit, rsp_installed, rsp_slot_index);
         end else begin
            want = pending_resps.pop_front();
            if ({rsp_hit, rsp_installed, rsp_slot_index} !== want) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display({"mismatch at cycle %0d: expected hit=%0b installed=%0b slot=%0d,",
                            " got hit=%0b installed=%0b slot=%0d"},
                           cycle_count, want.hit, want.installed, want.slot,
                           rsp_hit, rsp_installed, rsp_slot_index);
            end
         end
      end
   end

   // one transaction: present at the falling edge, hold until start && !busy at a rising edge
   task automatic issue_access(logic act, key_type key, logic fill);
      @(negedge clock);
      start        <= 1'b1;
      req_action   <= act;
      req_key_addr <= key;
      req_fill_ok  <= fill;
      do @(posedge clock); while (busy);
      pending_resps.push_back(predict_cache_access(act, key, fill));
   endtask

   task automatic idle_for(int n);
      @(negedge clock);
      start        <= 1'b0;
      req_action   <= 1'($urandom_range(1));
      req_key_addr <= rand_key();
      req_fill_ok  <= 1'($urandom_range(1));
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_resps.size() != 0) @(negedge clock);
   endtask

   // random gap, sometimes lined up after the response
   task automatic maybe_pause(int pct);
      if ($urandom_range(99) < pct) begin
         if ($urandom_range(3) == 0) wait_drained();
         idle_for($urandom_range(7, 1));
      end
   endtask

   task automatic test_cold_start();
      issue_access(ACT_LOOKUP, '0, 1'b0);
      issue_access(ACT_LOOKUP, '1, 1'b1);
      issue_access(ACT_LOOKUP, '1, 1'b0);
      issue_access(ACT_LOOKUP, '0, 1'b1);
      issue_access(ACT_LOOKUP, '0, 1'b0);
      issue_access(ACT_LOOKUP, {(KEYW/2){2'b10}}, 1'b1);
      issue_access(ACT_LOOKUP, {(KEYW/2){2'b01}}, 1'b1);
      issue_access(ACT_LOOKUP, key_type'(1), 1'b0);
      issue_access(ACT_LOOKUP, {(KEYW/2){2'b01}}, 1'b1);
      issue_access(ACT_CLEAR, '1, 1'b1);
      issue_access(ACT_LOOKUP, '1, 1'b1);
      issue_access(ACT_CLEAR, '0, 1'b0);
      issue_access(ACT_CLEAR, {(KEYW/2){2'b10}}, 1'b1);
      issue_access(ACT_LOOKUP, '0, 1'b0);
      issue_access(ACT_LOOKUP, '0, 1'b1);
      issue_access(ACT_LOOKUP, key_type'(1) << (KEYW - 1), 1'b1);
      issue_access(ACT_CLEAR, '1, 1'b0);
      issue_access(ACT_LOOKUP, key_type'(1) << (KEYW - 1), 1'b1);
   endtask

   task automatic test_fill_and_evict();
      key_type base;
      base = rand_key();
      wait_drained();
      idle_for(3);
      issue_access(ACT_CLEAR, rand_key(), 1'($urandom_range(1)));
      for (int i = 0; i < NSLOT; i++) begin
         maybe_pause(30);
         issue_access(ACT_LOOKUP, base + key_type'(i), 1'b1);
      end
      issue_access(ACT_LOOKUP, base, 1'b0);
      issue_access(ACT_LOOKUP, base + key_type'(5), 1'b0);
      for (int j = 0; j < 6; j++) begin
         maybe_pause(30);
         issue_access(ACT_LOOKUP, base + key_type'(NSLOT + j), 1'b1);
      end
      issue_access(ACT_LOOKUP, rand_key(), 1'b0);
      issue_access(ACT_LOOKUP, base + key_type'(1), 1'b1);
   endtask

   task automatic test_random_mix();
      key_type key_pool[128];
      int   pool_sz;
      int   pick;
      key_type key;
      pool_sz = 16;
      foreach (key_pool[i]) key_pool[i] = rand_key();
      for (int n = 0; n < RANDOM_TXNS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(3))
               0: pool_sz = 16;
               1: pool_sz = 60;
               2: pool_sz = 66;
               default: pool_sz = 128;
            endcase
         end
         if (n < RANDOM_TXNS - QUIET_TAIL) maybe_pause(25);
         pick = $urandom_range(99);
         if (pick < 3) begin
            issue_access(ACT_CLEAR, rand_key(), 1'($urandom_range(1)));
         end else begin
            if (pick < 8) key = rand_key();
            else if (pick < 9) key = $urandom_range(1) ? '1 : '0;
            else key = key_pool[$urandom_range(pool_sz - 1)];
            issue_access(ACT_LOOKUP, key, $urandom_range(99) < 85);
         end
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_cold_start();
      test_fill_and_evict();
      test_random_mix();
      idle_for(1);
      wait_drained();
      repeat (NSLOT + 8) @(negedge clock);
      fail_count += pending_resps.size();
      $display("covered %0d lookups: %0d hits, %0d installs (%0d evictions), %0d dry misses",
               n_lookups, n_hits, n_installs, n_evictions, n_dry_misses);
      $display("plus %0d clears; %0d responses checked, %0d failures",
               n_clears, resp_checked, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
